### hdl/assert_macros.svh
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hdl/pwstat_pkg.sv
// ----------------------------------------------------------------------------
// pwstat_pkg
// Shared types and constants of the per-sensor window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none
package pwstat_pkg;
  localparam int unsigned SENSORS_DEF     = 128;
  localparam int unsigned WINDOW_MAX_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam logic [4:0]  WINLEN_RESET    = 5'd10;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_PREP,
    ST_PREP2,
    ST_DIVIDE,
    ST_SCALE,
    ST_SQRT,
    ST_OUT
  } pws_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic rd;
    logic update;
    logic prep;
    logic div_start;
    logic div_step;
    logic scale;
    logic sqrt_start;
    logic sqrt_step;
    logic out_load;
  } pws_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic valid_id;
    logic is_flush;
    logic empty;
    logic close;
    logic div_done;
    logic sqrt_done;
  } pws_stat_t;
endpackage
`default_nettype wire

### hdl/pwstat_ctrl.sv
// ----------------------------------------------------------------------------
// pwstat_ctrl
// Sequencer: read the sensor entry, update it, then, when a window closes or
// an open window is flushed, run divide and root.
`default_nettype none
module pwstat_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire pwstat_pkg::pws_stat_t stat,
  output pwstat_pkg::pws_cmd_t       cmd
);
  import pwstat_pkg::*;

  pws_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (!stat.valid_id) state_nxt = ST_IDLE;
        else if (stat.is_flush) state_nxt = stat.empty ? ST_IDLE : ST_PREP;
        else state_nxt = stat.close ? ST_PREP : ST_IDLE;
      end
      ST_PREP:   state_nxt = ST_PREP2;
      ST_PREP2:  state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (stat.div_done) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_SQRT;
      ST_SQRT:   if (stat.sqrt_done) state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE:   begin in_stall = 1'b0; cmd.rd = in_valid; end
      ST_UPDATE: cmd.update = 1'b1;
      ST_PREP:   cmd.prep = 1'b1;
      ST_PREP2:  cmd.div_start = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_SCALE:  begin cmd.scale = 1'b1; cmd.sqrt_start = 1'b1; end
      ST_SQRT:   begin
        cmd.sqrt_step = 1'b1;
        cmd.out_load  = stat.sqrt_done;
      end
      ST_OUT:    out_valid = 1'b1;
      default:   ;
    endcase
  end
endmodule
`default_nettype wire

### hdl/pwstat_dp.sv
// ----------------------------------------------------------------------------
// pwstat_dp
// Datapath: per-sensor memories, window update, serial divider and root.
// ----------------------------------------------------------------------------
`default_nettype none
module pwstat_dp #(
  parameter int unsigned SENSORS     = 128,
  parameter int unsigned WINDOW_MAX  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pwstat_pkg::pws_cmd_t   cmd,
  output pwstat_pkg::pws_stat_t       stat,
  input  wire logic [4:0]             win_len,
  input  wire logic                   in_cmd,
  input  wire logic [6:0]             in_sensor,
  input  wire logic [15:0]            in_sample_value,
  output logic [6:0]                  out_sensor,
  output logic [4:0]                  out_sample_count,
  output logic [19:0]                 out_window_sum,
  output logic [15:0]                 out_window_min,
  output logic [15:0]                 out_window_max,
  output logic [23:0]                 out_mean_q8,
  output logic [22:0]                 out_stddev_q8,
  output logic                        out_partial
);
  import pwstat_pkg::*;

  localparam int unsigned IDW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned NW  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned SUMW = SB + NW;
  localparam int unsigned SQW  = 2 * SB + NW;
  localparam int unsigned DW   = 2 * NW;
  // Scaled variance width; root is half of it.
  localparam int unsigned VW   = 2 * SB + 16;
  localparam int unsigned RW   = VW / 2;
  // Numerator width: n times the sum of squares.
  localparam int unsigned NUMW = SQW + NW;

  // Per-sensor stores.
  logic [NW-1:0]   cnt_mem   [SENSORS];
  logic [SENSORS-1:0] cnt_vld_r;
  logic [SUMW-1:0] sum_mem   [SENSORS];
  logic [SQW-1:0]  sq_mem    [SENSORS];
  logic [SB-1:0]   min_mem   [SENSORS];
  logic [SB-1:0]   max_mem   [SENSORS];

  logic            cmd_r;
  logic [6:0]      id_r;
  logic [SB-1:0]   smp_r;
  logic            vid_r;
  logic [NW-1:0]   cnt_rd_r;
  logic            cvld_rd_r;
  logic [SUMW-1:0] sum_rd_r;
  logic [SQW-1:0]  sq_rd_r;
  logic [SB-1:0]   min_rd_r, max_rd_r;

  logic [NW-1:0]   n_r;
  logic [SUMW-1:0] s_r;
  logic [SQW-1:0]  q_r;
  logic [SB-1:0]   mn_r, mx_r;
  logic [DW-1:0]   d_r;

  logic [IDW-1:0]  idx;
  logic [NW-1:0]   cnt_cur;
  logic [NW-1:0]   eff_len;
  logic [NW-1:0]   cnt_new;
  logic [SUMW-1:0] sum_new;
  logic [SQW-1:0]  sq_new;
  logic [SB-1:0]   min_new, max_new;
  logic [2*SB-1:0] sqv;

  assign idx = id_r[IDW-1:0];
  assign cnt_cur = cvld_rd_r ? cnt_rd_r : '0;

  // Capture the beat and read the entry.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      cmd_r <= in_cmd;
      id_r  <= in_sensor;
      smp_r <= in_sample_value[SB-1:0];
      vid_r <= ({25'd0, in_sensor} < 32'(SENSORS));
    end
    if (cmd.rd) begin
      cnt_rd_r  <= cnt_mem[in_sensor[IDW-1:0]];
      cvld_rd_r <= cnt_vld_r[in_sensor[IDW-1:0]];
      sum_rd_r  <= sum_mem[in_sensor[IDW-1:0]];
      sq_rd_r   <= sq_mem[in_sensor[IDW-1:0]];
      min_rd_r  <= min_mem[in_sensor[IDW-1:0]];
      max_rd_r  <= max_mem[in_sensor[IDW-1:0]];
    end
  end

  // Effective window length, clamped to one through the maximum.
  always_comb begin
    if (win_len == 5'd0) eff_len = NW'(1);
    else if ({27'd0, win_len} > 32'(WINDOW_MAX)) eff_len = NW'(WINDOW_MAX);
    else eff_len = NW'(win_len);
  end

  // Window update.
  always_comb begin
    sqv = smp_r * smp_r;
    if (cnt_cur == '0) begin
      sum_new = SUMW'(smp_r);
      sq_new  = SQW'(sqv);
      min_new = smp_r;
      max_new = smp_r;
    end else begin
      sum_new = sum_rd_r + SUMW'(smp_r);
      sq_new  = sq_rd_r + SQW'(sqv);
      min_new = (smp_r < min_rd_r) ? smp_r : min_rd_r;
      max_new = (smp_r > max_rd_r) ? smp_r : max_rd_r;
    end
    cnt_new = cnt_cur + NW'(1);
  end

  assign stat.valid_id = vid_r;
  assign stat.is_flush = (cmd_r == CMD_FLUSH);
  assign stat.empty    = (cnt_cur == '0);
  assign stat.close    = (cnt_new >= eff_len);

  // Store write and valid bits.
  always_ff @(posedge clk) begin
    if (cmd.update && vid_r) begin
      if (cmd_r == CMD_ADD) begin
        sum_mem[idx] <= sum_new;
        sq_mem[idx]  <= sq_new;
        min_mem[idx] <= min_new;
        max_mem[idx] <= max_new;
      end
      if (cmd_r == CMD_ADD && !(cnt_new >= eff_len)) cnt_mem[idx] <= cnt_new;
      else cnt_mem[idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_vld_r <= '0;
    else if (cmd.update && vid_r) cnt_vld_r[idx] <= 1'b1;
  end

  // Latch window values for reporting.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (cmd_r == CMD_ADD) begin
        n_r <= cnt_new; s_r <= sum_new; q_r <= sq_new;
        mn_r <= min_new; mx_r <= max_new;
      end else begin
        n_r <= cnt_cur; s_r <= sum_rd_r; q_r <= sq_rd_r;
        mn_r <= min_rd_r; mx_r <= max_rd_r;
      end
    end
  end

  // Numerator products: n*sumsq, sum^2 and n^2.
  logic [NUMW-1:0]   nq_r;
  logic [2*SUMW-1:0] ss_r;
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      nq_r <= NUMW'(n_r) * q_r;
      ss_r <= s_r * s_r;
      d_r  <= n_r * n_r;
    end
  end

  // Restoring divider: num*65536/d and sum*256/n share the loop count.
  localparam int unsigned QW  = NUMW + 16;
  localparam int unsigned MQW = SUMW + 8;
  localparam int unsigned CW  = $clog2(QW + 1);
  logic [QW-1:0]  dq_r;
  logic [DW:0]    dr_r;
  logic [MQW-1:0] mq_r;
  logic [NW:0]    mr_r;
  logic [CW-1:0]  dcnt_r;
  logic [DW:0]    dtry;
  logic [NW:0]    mtry;

  always_comb begin
    dtry = {dr_r[DW-1:0], dq_r[QW-1]} - {1'b0, d_r};
    mtry = {mr_r[NW-1:0], mq_r[MQW-1]} - {1'b0, n_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r   <= {nq_r - NUMW'(ss_r), 16'd0};
      dr_r   <= '0;
      mq_r   <= {s_r, 8'd0};
      mr_r   <= '0;
      dcnt_r <= CW'(QW);
    end else if (cmd.div_step && dcnt_r != '0) begin
      if (!dtry[DW]) begin
        dr_r <= dtry;
        dq_r <= {dq_r[QW-2:0], 1'b1};
      end else begin
        dr_r <= {dr_r[DW-1:0], dq_r[QW-1]};
        dq_r <= {dq_r[QW-2:0], 1'b0};
      end
      if ({{(32-CW){1'b0}}, dcnt_r} <= 32'(MQW)) begin
        if (!mtry[NW]) begin
          mr_r <= mtry;
          mq_r <= {mq_r[MQW-2:0], 1'b1};
        end else begin
          mr_r <= {mr_r[NW-1:0], mq_r[MQW-1]};
          mq_r <= {mq_r[MQW-2:0], 1'b0};
        end
      end
      dcnt_r <= dcnt_r - CW'(1);
    end
  end
  assign stat.div_done = (dcnt_r == '0);

  // Bit-pair square root.
  localparam int unsigned SCW = $clog2(RW + 1);
  logic [VW-1:0]   sv_r;
  logic [RW+1:0]   sr_r;
  logic [RW-1:0]   root_r;
  logic [SCW-1:0]  scnt_r;
  logic [RW+1:0]   strial;
  logic [RW+1:0]   srem;
  always_comb begin
    srem   = {sr_r[RW-1:0], sv_r[VW-1 -: 2]};
    strial = srem - {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sv_r   <= dq_r[VW-1:0];
      sr_r   <= '0;
      root_r <= '0;
      scnt_r <= SCW'(RW);
    end else if (cmd.sqrt_step && scnt_r != '0) begin
      if (!strial[RW+1]) begin
        sr_r   <= strial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        sr_r   <= srem;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
      sv_r   <= {sv_r[VW-3:0], 2'b00};
      scnt_r <= scnt_r - SCW'(1);
    end
  end
  assign stat.sqrt_done = (scnt_r == SCW'(1));

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sensor       <= id_r;
      out_sample_count <= 5'(n_r);
      out_window_sum   <= 20'(s_r);
      out_window_min   <= 16'(mn_r);
      out_window_max   <= 16'(mx_r);
      out_mean_q8      <= 24'(mq_r);
      out_stddev_q8    <= 23'({root_r[RW-2:0], !strial[RW+1]});
      out_partial      <= (cmd_r == CMD_FLUSH);
    end
  end
endmodule
`default_nettype wire

### hdl/per_sensor_window_statistics.sv
// ----------------------------------------------------------------------------
// per_sensor_window_statistics
// Tumbling-window count, sum, min, max, mean and deviation for each sensor.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake         Payload
// in       input      in_valid/stall    cmd, sensor, sample_value
// out      output     out_valid/stall   sensor, count, sum, min, max, mean, sd
// cfg      input      cfg_write_en      window length
//
// A beat that does not close a window passes accept, read and update.
// A closing beat or a flush of an open window passes those, then the
// numerator products, the divider start, the restoring divide of a 58-bit
// quotient and its finish, the root start, a 24-bit root and the output register.
// The input stays stalled while the result waits under out_stall.
// Reset clears the count valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module per_sensor_window_statistics #(
  parameter int unsigned SENSORS     = pwstat_pkg::SENSORS_DEF,
  parameter int unsigned WINDOW_MAX  = pwstat_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = pwstat_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [6:0]  in_sensor,
  input  wire logic [15:0] in_sample_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_sensor,
  output logic [4:0]       out_sample_count,
  output logic [19:0]      out_window_sum,
  output logic [15:0]      out_window_min,
  output logic [15:0]      out_window_max,
  output logic [23:0]      out_mean_q8,
  output logic [22:0]      out_stddev_q8,
  output logic             out_partial,
  input  wire logic        cfg_write_en,
  input  wire logic [4:0]  cfg_window_length
);
  import pwstat_pkg::*;

  pws_cmd_t  cmd;
  pws_stat_t stat;
  logic [4:0] win_len_r;

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) win_len_r <= WINLEN_RESET;
    else if (cfg_write_en) win_len_r <= cfg_window_length;
  end

  pwstat_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd
  );

  pwstat_dp #(
    .SENSORS(SENSORS), .WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat, .win_len(win_len_r),
    .in_cmd, .in_sensor, .in_sample_value,
    .out_sensor, .out_sample_count, .out_window_sum, .out_window_min,
    .out_window_max, .out_mean_q8, .out_stddev_q8, .out_partial
  );

  // The input never opens while a result is pending.
  `ASSERT_IMPLIES(a_excl, clk, rst_n, out_valid, in_stall)
  // An accepted beat closes the input in the next cycle.
  `ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // A reported window holds at least one sample.
  `ASSERT_IMPLIES(a_cnt, clk, rst_n, out_valid, out_sample_count != 5'd0)
endmodule
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Window statistics testbench
// Drives sample and flush beats into the per-sensor window statistics block,
// predicts each closed or flushed window in software, and compares every
// result beat field by field. Covers several window lengths, including zero,
// one, sixteen and values above sixteen.
// ----------------------------------------------------------------------------
module tb;
  import pwstat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        cmd;
    logic [6:0]  sensor;
    logic [15:0] sample;
  } beat_t;

  typedef struct {
    logic [6:0]  sensor;
    logic [4:0]  count;
    logic [19:0] sum;
    logic [15:0] wmin;
    logic [15:0] wmax;
    logic [23:0] mean;
    logic [22:0] sd;
    logic        partial;
  } window_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [6:0]  in_sensor;
  logic [15:0] in_sample_value;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_sensor;
  logic [4:0]  out_sample_count;
  logic [19:0] out_window_sum;
  logic [15:0] out_window_min;
  logic [15:0] out_window_max;
  logic [23:0] out_mean_q8;
  logic [22:0] out_stddev_q8;
  logic        out_partial;
  logic        cfg_write_en;
  logic [4:0]  cfg_window_length;

  per_sensor_window_statistics dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_sensor(in_sensor), .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_sensor(out_sensor),
    .out_sample_count(out_sample_count), .out_window_sum(out_window_sum),
    .out_window_min(out_window_min), .out_window_max(out_window_max),
    .out_mean_q8(out_mean_q8), .out_stddev_q8(out_stddev_q8),
    .out_partial(out_partial), .cfg_write_en(cfg_write_en),
    .cfg_window_length(cfg_window_length)
  );

  // Predictor state: one open window per sensor.
  logic [4:0]  winlen_q;
  logic [4:0]  open_count [128];
  logic [19:0] open_sum [128];
  logic [35:0] open_sumsq [128];
  logic [15:0] open_min [128];
  logic [15:0] open_max [128];

  beat_t   pending_beats [$];
  window_t expected_windows [$];
  int      mismatches = 0;
  bit      quiet_idle = 0;
  bit      hold_send = 0;
  // Set at each rising edge when the presented input beat was taken.
  bit      in_taken = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Close the open window of sensor s and queue its statistics.
  function automatic void close_window(input int s, input logic partial);
    window_t w;
    logic [63:0] n, sum, num, den, q, r, scaled;
    n = 64'(open_count[s]);
    sum = 64'(open_sum[s]);
    num = n * 64'(open_sumsq[s]) - sum * sum;
    den = n * n;
    q = num / den;
    r = num % den;
    scaled = q * 65536 + (r * 65536) / den;
    w.sensor = s[6:0];
    w.count = n[4:0];
    w.sum = sum[19:0];
    w.wmin = open_min[s];
    w.wmax = open_max[s];
    w.mean = 24'((sum * 256) / n);
    w.sd = 23'(int_sqrt(scaled));
    w.partial = partial;
    expected_windows = {expected_windows, w};
    open_count[s] = 5'd0;
  endfunction

  function automatic void predict_beat(input beat_t b);
    int s;
    int eff;
    s = b.sensor;
    eff = (winlen_q == 0) ? 1 : (winlen_q > 16) ? 16 : winlen_q;
    if (b.cmd == CMD_FLUSH) begin
      if (open_count[s] != 0) close_window(s, 1'b1);
    end else begin
      if (open_count[s] == 0) begin
        open_sum[s] = 20'(b.sample);
        open_sumsq[s] = 36'(b.sample) * 36'(b.sample);
        open_min[s] = b.sample;
        open_max[s] = b.sample;
      end else begin
        open_sum[s] = open_sum[s] + 20'(b.sample);
        open_sumsq[s] = open_sumsq[s] + 36'(b.sample) * 36'(b.sample);
        if (b.sample < open_min[s]) open_min[s] = b.sample;
        if (b.sample > open_max[s]) open_max[s] = b.sample;
      end
      open_count[s] = open_count[s] + 5'd1;
      if (open_count[s] >= eff) close_window(s, 1'b0);
    end
  endfunction

  function automatic bit idle_now();
    return !quiet_idle && ($urandom_range(99) < 6);
  endfunction

  // Driver: present pending beats at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // Payload held while stalled.
      end else if (pending_beats.size() != 0 && !hold_send && !idle_now()) begin
        in_valid <= 1'b1;
        in_cmd <= pending_beats[0].cmd;
        in_sensor <= pending_beats[0].sensor;
        in_sample_value <= pending_beats[0].sample;
        void'(pending_beats.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= idle_now();
    end
  end

  // Monitor: predict accepted beats and check result beats.
  always @(posedge clk) begin
    beat_t b;
    window_t w;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        b.cmd = in_cmd;
        b.sensor = in_sensor;
        b.sample = in_sample_value;
        predict_beat(b);
      end
      if (out_valid && !out_stall) begin
        if (expected_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result for sensor %0d", out_sensor);
        end else begin
          w = expected_windows.pop_front();
          if (out_sensor !== w.sensor || out_sample_count !== w.count ||
              out_window_sum !== w.sum || out_window_min !== w.wmin ||
              out_window_max !== w.wmax || out_mean_q8 !== w.mean ||
              out_stddev_q8 !== w.sd || out_partial !== w.partial) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp s%0d n%0d sum%0d min%0d max%0d m%0d sd%0d p%0d",
                w.sensor, w.count, w.sum, w.wmin, w.wmax, w.mean, w.sd,
                w.partial);
              $display("         got s%0d n%0d sum%0d min%0d max%0d m%0d sd%0d p%0d",
                out_sensor, out_sample_count, out_window_sum, out_window_min,
                out_window_max, out_mean_q8, out_stddev_q8, out_partial);
            end
          end
        end
      end
    end
  end

  task automatic queue_beat(input logic cmd, input int s, input int v);
    beat_t b;
    b.cmd = cmd;
    b.sensor = s[6:0];
    b.sample = v[15:0];
    pending_beats = {pending_beats, b};
  endtask

  // Wait until every queued beat is taken and every window has come out.
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_windows.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_length(input logic [4:0] len);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_window_length <= len;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    winlen_q = len;
  endtask

  // Mostly sample beats on a few sensors so windows fill, some flushes.
  task automatic random_phase(input int count);
    int s;
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(7);
      case ($urandom_range(9))
        0: queue_beat(CMD_FLUSH, s, $urandom);
        1: queue_beat(CMD_ADD, s, $urandom_range(1) ? 16'hffff : 16'h0000);
        default: queue_beat(CMD_ADD, s, $urandom);
      endcase
    end
  endtask

  initial begin
    logic [4:0] lengths [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ADD;
    in_sensor = '0;
    in_sample_value = '0;
    out_stall = 1'b0;
    cfg_write_en = 1'b0;
    cfg_window_length = WINLEN_RESET;
    winlen_q = WINLEN_RESET;
    for (int i = 0; i < 128; i++) open_count[i] = 5'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset length of ten, extreme samples, flushes, top sensor.
    queue_beat(CMD_FLUSH, 5, 0);
    for (int i = 0; i < 10; i++) queue_beat(CMD_ADD, 127, (i % 2) ? 16'hffff : 0);
    for (int i = 0; i < 3; i++) queue_beat(CMD_ADD, 0, 16'hffff);
    queue_beat(CMD_FLUSH, 0, 16'hffff);
    queue_beat(CMD_FLUSH, 0, 0);
    queue_beat(CMD_ADD, 1, 16'h1234);
    queue_beat(CMD_ADD, 2, 16'h5555);
    drain();

    // Lowering the length to one closes an open window on its next sample.
    write_length(5'd1);
    queue_beat(CMD_ADD, 1, 16'haaaa);
    queue_beat(CMD_FLUSH, 2, 0);
    drain();
    write_length(5'd16);
    for (int i = 0; i < 16; i++) queue_beat(CMD_ADD, 3, 16'hffff);
    drain();

    // Random phases over several lengths, zero and oversize among them.
    lengths = '{5'd0, 5'd31, 5'd3, 5'd16, 5'd1, 5'd7};
    for (int p = 0; p < 6; p++) begin
      write_length(lengths[p]);
      if (p == 3) quiet_idle = 1;
      random_phase(195);
      if (p == 2) begin
        // Sender holds off mid phase until every result is out.
        while (pending_beats.size() > 100) @(posedge clk);
        hold_send = 1;
        while (in_valid || expected_windows.size() != 0) @(posedge clk);
        hold_send = 0;
      end
      drain();
      quiet_idle = 0;
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
